/* sv/chacha20_stream_cipher_assert.svh */
`ifndef CHACHA20_STREAM_CIPHER_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_ASSERT_SVH
// Assertion helpers shared by the checker.
`define CHK_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed");
`endif

/* sv/chacha_pkg.sv */
package chacha_pkg;
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;
    localparam int unsigned DOUBLE_ROUNDS = 10;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_NONCE_LO = 3'd4;
    localparam logic [2:0] REG_NONCE_HI = 3'd5;
    localparam logic [2:0] REG_COUNTER = 3'd6;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] block_t;

    typedef struct packed {
        logic load;      // build initial state into working words
        logic round;     // run one column or diagonal half round
        logic diag;      // half round selects diagonals
        logic finish;    // add initial state, store keystream
        logic emit;      // take input byte into output register
        logic pop;       // output register emptied
    } cmd_t;

    typedef struct packed {
        logic need_block;   // byte position zero
        logic out_full;
    } status_t;

    function automatic word_t rotl(input word_t v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] qr(input word_t a, input word_t b,
                                        input word_t c, input word_t d);
        word_t a1, b1, c1, d1;
        a1 = a + b;   d1 = rotl(d ^ a1, 16);
        c1 = c + d1;  b1 = rotl(b ^ c1, 12);
        a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
        c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
        qr = {a1, b1, c1, d1};
    endfunction
endpackage

/* sv/chacha_datapath.sv */
module chacha_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    input  chacha_pkg::cmd_t     cmd,
    output chacha_pkg::status_t  status,
    input  logic [7:0]           plain_byte,
    input  logic                 in_last,
    output logic [7:0]           cipher_byte,
    output logic                 out_last,
    output logic                 out_valid
);
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce_lo_reg;
    logic [31:0] nonce_hi_reg, init_ctr_reg, count_reg;
    logic [5:0]  pos_reg;
    chacha_pkg::block_t work_reg, work_next, init_blk, ks_reg;
    logic [7:0]  cipher_reg;
    logic        last_reg, valid_reg;
    logic [31:0] ks_word;

    always_comb
    begin
        init_blk[0] = chacha_pkg::SIGMA0;
        init_blk[1] = chacha_pkg::SIGMA1;
        init_blk[2] = chacha_pkg::SIGMA2;
        init_blk[3] = chacha_pkg::SIGMA3;
        init_blk[4] = key0_reg[31:0];
        init_blk[5] = key0_reg[63:32];
        init_blk[6] = key1_reg[31:0];
        init_blk[7] = key1_reg[63:32];
        init_blk[8] = key2_reg[31:0];
        init_blk[9] = key2_reg[63:32];
        init_blk[10] = key3_reg[31:0];
        init_blk[11] = key3_reg[63:32];
        init_blk[12] = count_reg;
        init_blk[13] = nonce_lo_reg[31:0];
        init_blk[14] = nonce_lo_reg[63:32];
        init_blk[15] = nonce_hi_reg;
    end

    always_comb
    begin
        work_next = work_reg;
        if (!cmd.diag)
        begin
            for (int i = 0; i < 4; i++)
            begin
                {work_next[i], work_next[4+i], work_next[8+i], work_next[12+i]} =
                    chacha_pkg::qr(work_reg[i], work_reg[4+i], work_reg[8+i],
                                   work_reg[12+i]);
            end
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                {work_next[i], work_next[4+(i+1)%4], work_next[8+(i+2)%4],
                 work_next[12+(i+3)%4]} =
                    chacha_pkg::qr(work_reg[i], work_reg[4+(i+1)%4],
                                   work_reg[8+(i+2)%4], work_reg[12+(i+3)%4]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            work_reg <= init_blk;
        else if (cmd.round)
            work_reg <= work_next;
        if (cmd.finish)
        begin
            for (int i = 0; i < 16; i++)
                ks_reg[i] <= work_reg[i] + init_blk[i];
        end
    end

    assign ks_word = ks_reg[pos_reg[5:2]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0; key1_reg <= '0; key2_reg <= '0; key3_reg <= '0;
            nonce_lo_reg <= '0; nonce_hi_reg <= '0; init_ctr_reg <= '0;
            count_reg <= '0; pos_reg <= '0; valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                valid_reg <= 1'b1;
            else if (cmd.pop)
                valid_reg <= 1'b0;
            // a counter write restarts the message
            if (cfg_we && (cfg_index == chacha_pkg::REG_COUNTER))
            begin
                count_reg <= cfg_data[31:0];
                pos_reg <= '0;
            end
            else if (cmd.emit)
            begin
                if (in_last)
                begin
                    pos_reg <= '0;
                    count_reg <= init_ctr_reg;
                end
                else
                begin
                    pos_reg <= pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                        count_reg <= count_reg + 32'd1;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    chacha_pkg::REG_KEY0:     key0_reg <= cfg_data;
                    chacha_pkg::REG_KEY1:     key1_reg <= cfg_data;
                    chacha_pkg::REG_KEY2:     key2_reg <= cfg_data;
                    chacha_pkg::REG_KEY3:     key3_reg <= cfg_data;
                    chacha_pkg::REG_NONCE_LO: nonce_lo_reg <= cfg_data;
                    chacha_pkg::REG_NONCE_HI: nonce_hi_reg <= cfg_data[31:0];
                    chacha_pkg::REG_COUNTER:  init_ctr_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            cipher_reg <= plain_byte ^ ks_word[{pos_reg[1:0], 3'b000} +: 8];
            last_reg <= in_last;
        end
    end

    assign status.need_block = (pos_reg == 6'd0);
    assign status.out_full = valid_reg;
    assign cipher_byte = cipher_reg;
    assign out_last = last_reg;
    assign out_valid = valid_reg;
endmodule

/* sv/chacha_ctrl.sv */
module chacha_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                out_stall,
    input  chacha_pkg::status_t status,
    output chacha_pkg::cmd_t    cmd
);
    typedef enum logic [3:0] {
        ST_READY  = 4'b0001,
        ST_ROUND  = 4'b0010,
        ST_FINISH = 4'b0100,
        ST_HAVE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] half_reg, half_next;
    logic pop, can_take;

    assign pop = status.out_full && !out_stall;
    assign can_take = !status.out_full || pop;

    always_comb
    begin
        state_next = state_reg;
        half_next = half_reg;
        cmd = '0;
        cmd.pop = pop;
        cmd.diag = half_reg[0];
        in_stall = 1'b1;
        case (state_reg)
            ST_READY:
            begin
                // hold input until a keystream block is ready
                if (in_valid && status.need_block)
                begin
                    cmd.load = 1'b1;
                    half_next = '0;
                    state_next = ST_ROUND;
                end
                else
                begin
                    in_stall = !can_take;
                    cmd.emit = in_valid && can_take;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                half_next = half_reg + 5'd1;
                if (half_reg == 5'(2 * chacha_pkg::DOUBLE_ROUNDS - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_HAVE;
            end
            ST_HAVE:
            begin
                in_stall = !can_take;
                cmd.emit = in_valid && can_take;
                if (cmd.emit)
                    state_next = ST_READY;
            end
            default: state_next = ST_READY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_READY;
            half_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg <= half_next;
        end
    end
endmodule

/* sv/chacha20_stream_cipher.sv */
// ChaCha20 stream cipher, one byte per transfer.
// Input channel: plain_byte/in_last with in_valid, held back by in_stall.
// Output channel: cipher_byte/out_last with out_valid; the receiver drives
// out_stall. Exactly one output byte per input byte, in order.
// Configuration: cfg_we writes cfg_data to register cfg_index (0..3 key,
// 4/5 nonce, 6 initial counter); writing the counter restarts the message.
// Timing: a byte within a block reaches the output register in the cycle
// after its transfer; while the receiver does not stall, a byte stream runs at one byte per cycle.
// At each block start (byte position zero) the first byte waits for one load,
// 20 half rounds of four parallel quarter rounds and one final add.
// After a byte marked last, position and counter return to start values.
// Reset clears the configuration, counter and position registers to zero and empties the output register.
// While the receiver stalls, the output holds and in_stall rises once the
// output register is full and not drained in the same cycle.
module chacha20_stream_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  plain_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  cipher_byte,
    output logic        out_last
);
    chacha_pkg::cmd_t    cmd;
    chacha_pkg::status_t status;

    chacha_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_stall(out_stall), .status(status), .cmd(cmd)
    );

    chacha_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd(cmd), .status(status),
        .plain_byte(plain_byte), .in_last(in_last), .cipher_byte(cipher_byte),
        .out_last(out_last), .out_valid(out_valid)
    );
endmodule

/* sv/chacha_checker.sv */
`include "chacha20_stream_cipher_assert.svh"
module chacha_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] cipher_byte,
    input logic       out_last
);
    // a stalled result holds
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(cipher_byte) && $stable(out_last))
    // an input transfer always lands in the output register
    `CHK_NEXT(a_in_to_out, clk, rst_n, in_valid && !in_stall, out_valid)
    // input is taken only when room exists in the output register
    `CHK_IMPLIES(a_room, clk, rst_n, in_valid && !in_stall && out_valid, !out_stall)
endmodule

bind chacha20_stream_cipher chacha_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cipher_byte(cipher_byte),
    .out_last(out_last)
);
